>>> src/sedu_pkg.sv
// ----------------------------------------------------------------------------
// String literal escape decoder package
// Shared types, codes and character constants of the escape decoder.
// ----------------------------------------------------------------------------
package sedu_pkg;

    localparam int unsigned P_MAX_LEN = 4096;
    localparam int unsigned RES_MAX   = 3;
    localparam int unsigned RES_CNT_W = 2;
    localparam int unsigned LEN_W     = 13;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_OCT    = 2'd2,
        MODE_HEX    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_UNTERM = 3'd1,
        ERR_ESCAPE = 3'd2,
        ERR_OCT    = 3'd3,
        ERR_HEX    = 3'd4
    } t_err;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data_byte;
        t_err             error_code;
        logic [LEN_W-1:0] string_length;
    } t_res;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    localparam logic [7:0] BYTE_MAX = 8'hFF;

endpackage

>>> src/string_literal_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// String literal escape decoder unit
// Decodes the body of a string literal one character per request into data
// bytes, an end-of-string result or an error.
// ----------------------------------------------------------------------------
// A character is taken every cycle as long as each one gives at most one
// result and the output is not stalled; a character that gives two or three
// results holds the channel until all are taken, because the result buffer
// hands out one result per cycle while the output is not stalled. A character
// passes the input register, then the decode logic into the result buffer.
// The decoder state is updated as the character leaves the input register,
// so a character that gives no result never waits.
module string_literal_escape_decoder_unit #(
    parameter int unsigned MAX_LEN = sedu_pkg::P_MAX_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_char_in,
    input  logic                       i_last_in_line,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_data_byte,
    output logic [2:0]                 o_error_code,
    output logic [sedu_pkg::LEN_W-1:0] o_string_length,
    output logic                       o_last_of_run
);
    import sedu_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    logic                 r_in_valid;
    logic [7:0]           r_char;
    logic                 r_eol;
    t_mode                r_mode;
    logic [7:0]           r_value;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_count;

    t_mode                n_mode;
    logic [7:0]           n_value;
    logic                 n_ovf;
    logic [CNT_W-1:0]     n_count;

    logic                 w_closed;
    logic [RES_CNT_W-1:0] w_n;
    t_res                 w_res [RES_MAX];
    logic                 w_free;
    logic                 w_adv;
    logic                 w_in_take;

    assign w_adv      = r_in_valid && ((w_n == '0) || w_free);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_char <= i_char_in;
            r_eol  <= i_last_in_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_value <= '0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else if (w_adv) begin
            r_mode  <= n_mode;
            r_value <= n_value;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

    sedu_decode #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_decode (
        .i_char   (r_char),
        .i_eol    (r_eol),
        .i_mode   (r_mode),
        .i_value  (r_value),
        .i_ovf    (r_ovf),
        .i_count  (r_count),
        .o_mode   (n_mode),
        .o_value  (n_value),
        .o_ovf    (n_ovf),
        .o_count  (n_count),
        .o_closed (w_closed),
        .o_n      (w_n),
        .o_res    (w_res)
    );

    sedu_rbuf u_rbuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_adv && (w_n != '0)),
        .i_n             (w_n),
        .i_res           (w_res),
        .o_free          (w_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_error_code    (o_error_code),
        .o_string_length (o_string_length),
        .o_last_of_run   (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_char) && $stable(r_eol)))
        else $error("Pending character lost before it was decoded.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_closed) |=> ((r_mode == MODE_NORMAL) && (r_count == '0) && !r_ovf))
        else $error("Decoder state not cleared after the string closed.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("Decoded length went past its saturation value.");
`endif

endmodule

>>> src/sedu_decode.sv
// ----------------------------------------------------------------------------
// Escape decoder step logic
// Decodes one registered character against the current decoder state and
// produces up to three results together with the next state.
// ----------------------------------------------------------------------------
module sedu_decode #(
    parameter int unsigned MAX_LEN = sedu_pkg::P_MAX_LEN,
    parameter int unsigned CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic [7:0]                  i_char,
    input  logic                        i_eol,
    input  sedu_pkg::t_mode             i_mode,
    input  logic [7:0]                  i_value,
    input  logic                        i_ovf,
    input  logic [CNT_W-1:0]            i_count,
    output sedu_pkg::t_mode             o_mode,
    output logic [7:0]                  o_value,
    output logic                        o_ovf,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_closed,
    output logic [sedu_pkg::RES_CNT_W-1:0] o_n,
    output sedu_pkg::t_res              o_res [sedu_pkg::RES_MAX]
);
    import sedu_pkg::*;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c < CNT_W'(MAX_LEN)) begin
            r = c + 1'b1;
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic t_res mk_res(input t_kind k, input logic [7:0] b,
                                    input t_err e, input logic [LEN_W-1:0] len);
        t_res r;
        r.kind          = k;
        r.data_byte     = b;
        r.error_code    = e;
        r.string_length = len;
        return r;
    endfunction

    logic        w_oct_dig;
    logic        w_hex_dig;
    logic [7:0]  w_dsub;
    logic [3:0]  w_dval;

    always_comb begin
        w_oct_dig = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);
        w_hex_dig = w_oct_dig || (i_char == CH_EIGHT) || (i_char == CH_NINE)
                    || ((i_char >= CH_LC_A) && (i_char <= CH_LC_F))
                    || ((i_char >= CH_UC_A) && (i_char <= CH_UC_F));
        priority if ((i_char >= CH_LC_A) && (i_char <= CH_LC_F)) begin
            w_dsub = i_char - (CH_LC_A - 8'd10);
        end else if ((i_char >= CH_UC_A) && (i_char <= CH_UC_F)) begin
            w_dsub = i_char - (CH_UC_A - 8'd10);
        end else begin
            w_dsub = i_char - CH_ZERO;
        end
        w_dval = w_dsub[3:0];
    end

    always_comb begin
        t_mode            m;
        logic [7:0]       v;
        logic             ov;
        logic [CNT_W-1:0] cnt;
        logic [RES_CNT_W-1:0] n;
        logic             open;
        logic             done;
        logic             closed;
        logic             is_dig;
        logic [11:0]      wide;
        logic [7:0]       b;
        logic             known;
        t_res             res [RES_MAX];

        m      = i_mode;
        v      = i_value;
        ov     = i_ovf;
        cnt    = i_count;
        n      = '0;
        open   = 1'b1;
        done   = 1'b0;
        closed = 1'b0;
        b      = '0;
        known  = 1'b1;
        wide   = '0;
        for (int k = 0; k < RES_MAX; k++) begin
            res[k] = mk_res(KIND_DATA, '0, ERR_NONE, '0);
        end

        if ((m == MODE_OCT) || (m == MODE_HEX)) begin
            is_dig = (m == MODE_HEX) ? w_hex_dig : w_oct_dig;
            if (is_dig) begin
                if (m == MODE_HEX) begin
                    wide = {v, 4'b0000} + {8'd0, w_dval};
                end else begin
                    wide = {1'b0, v, 3'b000} + {8'd0, w_dval};
                end
                if (wide > {4'd0, BYTE_MAX}) begin
                    ov = 1'b1;
                end
                v    = wide[7:0];
                done = 1'b1;
            end else if (ov) begin
                res[n] = mk_res(KIND_ERR, '0, (m == MODE_OCT) ? ERR_OCT : ERR_HEX, '0);
                n      = n + 1'b1;
                m      = MODE_NORMAL;
                v      = '0;
                ov     = 1'b0;
                cnt    = '0;
                closed = 1'b1;
                open   = 1'b0;
                done   = 1'b1;
            end else begin
                res[n] = mk_res(KIND_DATA, v, ERR_NONE, '0);
                n      = n + 1'b1;
                cnt    = sat_inc(cnt);
                m      = MODE_NORMAL;
                v      = '0;
            end
        end else begin
            is_dig = 1'b0;
        end

        if (!done && open) begin
            if (m == MODE_NORMAL) begin
                priority if (i_char == CH_QUOTE) begin
                    res[n] = mk_res(KIND_END, '0, ERR_NONE, LEN_W'(cnt));
                    n      = n + 1'b1;
                    m      = MODE_NORMAL;
                    v      = '0;
                    ov     = 1'b0;
                    cnt    = '0;
                    closed = 1'b1;
                    open   = 1'b0;
                end else if (i_char == CH_BSLASH) begin
                    m = MODE_ESC;
                end else begin
                    res[n] = mk_res(KIND_DATA, i_char, ERR_NONE, '0);
                    n      = n + 1'b1;
                    cnt    = sat_inc(cnt);
                end
            end else begin
                m = MODE_NORMAL;
                unique case (i_char)
                    CH_LC_A:   b = BYTE_BEL;
                    CH_LC_B:   b = BYTE_BS;
                    CH_LC_T:   b = BYTE_TAB;
                    CH_LC_N:   b = BYTE_LF;
                    CH_LC_V:   b = BYTE_VT;
                    CH_LC_F:   b = BYTE_FF;
                    CH_LC_R:   b = BYTE_CR;
                    CH_BSLASH: b = i_char;
                    CH_APOS:   b = i_char;
                    CH_QUOTE:  b = i_char;
                    CH_ZERO: begin
                        m  = MODE_OCT;
                        v  = '0;
                        ov = 1'b0;
                    end
                    CH_LC_X: begin
                        m  = MODE_HEX;
                        v  = '0;
                        ov = 1'b0;
                    end
                    default:   known = 1'b0;
                endcase
                if (!known) begin
                    res[n] = mk_res(KIND_ERR, '0, ERR_ESCAPE, '0);
                    n      = n + 1'b1;
                    m      = MODE_NORMAL;
                    v      = '0;
                    ov     = 1'b0;
                    cnt    = '0;
                    closed = 1'b1;
                    open   = 1'b0;
                end else if (m == MODE_NORMAL) begin
                    res[n] = mk_res(KIND_DATA, b, ERR_NONE, '0);
                    n      = n + 1'b1;
                    cnt    = sat_inc(cnt);
                end
            end
        end

        if (open && i_eol) begin
            if ((m == MODE_OCT) || (m == MODE_HEX)) begin
                if (ov) begin
                    res[n] = mk_res(KIND_ERR, '0, (m == MODE_OCT) ? ERR_OCT : ERR_HEX, '0);
                    n      = n + 1'b1;
                    open   = 1'b0;
                end else begin
                    res[n] = mk_res(KIND_DATA, v, ERR_NONE, '0);
                    n      = n + 1'b1;
                end
            end
            if (open) begin
                res[n] = mk_res(KIND_ERR, '0, ERR_UNTERM, '0);
                n      = n + 1'b1;
            end
            m      = MODE_NORMAL;
            v      = '0;
            ov     = 1'b0;
            cnt    = '0;
            closed = 1'b1;
        end

        o_mode   = m;
        o_value  = v;
        o_ovf    = ov;
        o_count  = cnt;
        o_closed = closed;
        o_n      = n;
        o_res    = res;
    end

endmodule

>>> src/sedu_rbuf.sv
// ----------------------------------------------------------------------------
// Escape decoder result buffer
// Holds the results of one decoded character and hands them out one per
// request on the output channel.
// ----------------------------------------------------------------------------
module sedu_rbuf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [sedu_pkg::RES_CNT_W-1:0] i_n,
    input  sedu_pkg::t_res                 i_res [sedu_pkg::RES_MAX],
    output logic                           o_free,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_data_byte,
    output logic [2:0]                     o_error_code,
    output logic [sedu_pkg::LEN_W-1:0]     o_string_length,
    output logic                           o_last_of_run
);
    import sedu_pkg::*;

    logic [RES_CNT_W-1:0] r_left;
    logic [RES_CNT_W-1:0] r_idx;
    t_res                 r_res [RES_MAX];
    logic                 w_take;
    t_res                 w_cur;

    assign w_take = (r_left != '0) && !i_out_stall;
    assign o_free = (r_left == '0) || ((r_left == RES_CNT_W'(1)) && w_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_n;
            r_idx  <= '0;
        end else if (w_take) begin
            r_left <= r_left - 1'b1;
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign w_cur           = r_res[r_idx];
    assign o_out_valid     = (r_left != '0);
    assign o_kind          = w_cur.kind;
    assign o_data_byte     = w_cur.data_byte;
    assign o_error_code    = w_cur.error_code;
    assign o_string_length = w_cur.string_length;
    assign o_last_of_run   = (r_left == RES_CNT_W'(1));

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("Result buffer loaded while results are still pending.");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= RES_CNT_W'(RES_MAX))
        else $error("Result buffer count exceeds its depth.");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run && !i_out_stall && !i_load) |=> !o_out_valid)
        else $error("Result buffer still valid after its last result was taken.");
`endif

endmodule

>>> bench/tb_string_literal_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// String literal escape decoder unit testbench
// Feeds characters of string literal bodies through the valid/stall request
// channel: a table of directed characters, then random strings built from
// plain characters, escapes, numeric escapes, broken endings and noise. Both
// channels idle and stall at random. Each result is checked against a typed
// row's table entry or an in-bench decoder model fed the accepted requests.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_decoder_unit;
    import sedu_pkg::*;

    localparam int unsigned LEN_CAP     = P_MAX_LEN;
    localparam int          RANDOM_REQS = 200;
    localparam int          ROW_COUNT   = 26;

    typedef struct packed {
        t_res res;
        logic last_of_run;
    } t_expect;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       typed;
        t_res       res;
    } t_row;

    localparam t_res NO_RES = '{KIND_DATA, 8'h00, ERR_NONE, 13'd0};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_char_in;
    logic             i_last_in_line;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [1:0]       o_kind;
    logic [7:0]       o_data_byte;
    logic [2:0]       o_error_code;
    logic [LEN_W-1:0] o_string_length;
    logic             o_last_of_run;

    t_mode            dec_mode;
    logic [7:0]       esc_val;
    logic             esc_ovf;
    logic [LEN_W-1:0] char_count;

    t_expect step_results[$];
    t_expect decoded_expect[$];
    int      fail_count    = 0;
    int      requests_sent = 0;
    bit      in_no_gaps    = 1'b0;
    bit      out_no_stalls = 1'b0;

    t_row directed_rows [ROW_COUNT] = '{
        '{8'h00,          1'b0, 1'b1, '{KIND_DATA, 8'h00, ERR_NONE, 13'd0}},
        '{8'hFF,          1'b0, 1'b1, '{KIND_DATA, 8'hFF, ERR_NONE, 13'd0}},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{CH_LC_T,        1'b0, 1'b0, NO_RES},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{CH_ZERO,        1'b0, 1'b0, NO_RES},
        '{CH_ZERO + 8'd3, 1'b0, 1'b0, NO_RES},
        '{CH_SEVEN,       1'b1, 1'b0, NO_RES},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{CH_LC_X,        1'b0, 1'b0, NO_RES},
        '{CH_UC_A,        1'b0, 1'b0, NO_RES},
        '{8'h7A,          1'b1, 1'b0, NO_RES},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{CH_LC_X,        1'b0, 1'b0, NO_RES},
        '{CH_UC_F,        1'b0, 1'b0, NO_RES},
        '{CH_LC_F,        1'b0, 1'b0, NO_RES},
        '{CH_NINE,        1'b0, 1'b0, NO_RES},
        '{CH_QUOTE,       1'b0, 1'b1, '{KIND_ERR, 8'h00, ERR_HEX, 13'd0}},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{CH_ZERO,        1'b0, 1'b0, NO_RES},
        '{CH_SEVEN,       1'b0, 1'b0, NO_RES},
        '{CH_SEVEN,       1'b0, 1'b0, NO_RES},
        '{CH_SEVEN,       1'b1, 1'b1, '{KIND_ERR, 8'h00, ERR_OCT, 13'd0}},
        '{CH_BSLASH,      1'b0, 1'b0, NO_RES},
        '{8'h71,          1'b0, 1'b1, '{KIND_ERR, 8'h00, ERR_ESCAPE, 13'd0}},
        '{CH_QUOTE,       1'b0, 1'b1, '{KIND_END, 8'h00, ERR_NONE, 13'd0}}
    };

    logic [7:0] ESC_LETTERS [10] = '{CH_LC_A, CH_LC_B, CH_LC_T, CH_LC_N, CH_LC_V,
                                     CH_LC_F, CH_LC_R, CH_BSLASH, CH_APOS, CH_QUOTE};

    string_literal_escape_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .i_last_in_line  (i_last_in_line),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_error_code    (o_error_code),
        .o_string_length (o_string_length),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void put_result(t_kind kind, logic [7:0] data_v, t_err err,
                                       logic [LEN_W-1:0] len);
        t_expect x;
        x.res.kind          = kind;
        x.res.data_byte     = data_v;
        x.res.error_code    = err;
        x.res.string_length = len;
        x.last_of_run       = 1'b0;
        step_results.push_back(x);
    endfunction

    function automatic void put_byte(logic [7:0] data_v);
        put_result(KIND_DATA, data_v, ERR_NONE, '0);
        if (char_count < LEN_CAP) begin
            char_count++;
        end
    endfunction

    function automatic void start_string();
        dec_mode   = MODE_NORMAL;
        esc_val    = '0;
        esc_ovf    = 1'b0;
        char_count = '0;
    endfunction

    function automatic void mark_last();
        t_expect x;
        if (step_results.size() > 0) begin
            x = step_results.pop_back();
            x.last_of_run = 1'b1;
            step_results.push_back(x);
        end
    endfunction

    // A numeric escape ends here; an overflowed one ends the whole string.
    function automatic bit close_escape();
        if (esc_ovf) begin
            if (dec_mode == MODE_OCT) begin
                put_result(KIND_ERR, 8'h00, ERR_OCT, '0);
            end else begin
                put_result(KIND_ERR, 8'h00, ERR_HEX, '0);
            end
            start_string();
            return 1'b0;
        end
        put_byte(esc_val);
        dec_mode = MODE_NORMAL;
        esc_val  = '0;
        return 1'b1;
    endfunction

    function automatic void decode_char(logic [7:0] c, logic eol);
        bit         open;
        bit         used;
        bit         hex;
        bit         known;
        int         d;
        int         v;
        logic [7:0] b;
        open = 1'b1;
        used = 1'b0;
        d    = -1;
        step_results.delete();
        if (dec_mode == MODE_OCT || dec_mode == MODE_HEX) begin
            hex = (dec_mode == MODE_HEX);
            if (c >= CH_ZERO && c <= CH_SEVEN) begin
                d = c - CH_ZERO;
            end else if (hex && c >= CH_EIGHT && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (hex && c >= CH_LC_A && c <= CH_LC_F) begin
                d = c - CH_LC_A + 10;
            end else if (hex && c >= CH_UC_A && c <= CH_UC_F) begin
                d = c - CH_UC_A + 10;
            end
            if (d >= 0) begin
                v = esc_val * (hex ? 16 : 8) + d;
                if (v > 255) begin
                    esc_ovf = 1'b1;
                end
                esc_val = v[7:0];
                used    = 1'b1;
            end else if (!close_escape()) begin
                open = 1'b0;
                used = 1'b1;
            end
        end
        if (!used && open) begin
            if (dec_mode == MODE_NORMAL) begin
                if (c == CH_QUOTE) begin
                    put_result(KIND_END, 8'h00, ERR_NONE, char_count);
                    start_string();
                    open = 1'b0;
                end else if (c == CH_BSLASH) begin
                    dec_mode = MODE_ESC;
                end else begin
                    put_byte(c);
                end
            end else begin
                known    = 1'b1;
                b        = '0;
                dec_mode = MODE_NORMAL;
                case (c)
                    CH_LC_A: b = BYTE_BEL;
                    CH_LC_B: b = BYTE_BS;
                    CH_LC_T: b = BYTE_TAB;
                    CH_LC_N: b = BYTE_LF;
                    CH_LC_V: b = BYTE_VT;
                    CH_LC_F: b = BYTE_FF;
                    CH_LC_R: b = BYTE_CR;
                    CH_BSLASH, CH_APOS, CH_QUOTE: b = c;
                    CH_ZERO: begin
                        dec_mode = MODE_OCT;
                        esc_val  = '0;
                        esc_ovf  = 1'b0;
                    end
                    CH_LC_X: begin
                        dec_mode = MODE_HEX;
                        esc_val  = '0;
                        esc_ovf  = 1'b0;
                    end
                    default: known = 1'b0;
                endcase
                if (!known) begin
                    put_result(KIND_ERR, 8'h00, ERR_ESCAPE, '0);
                    start_string();
                    open = 1'b0;
                end else if (dec_mode == MODE_NORMAL) begin
                    put_byte(b);
                end
            end
        end
        if (open && eol) begin
            if (dec_mode == MODE_OCT || dec_mode == MODE_HEX) begin
                open = close_escape();
            end
            if (open) begin
                put_result(KIND_ERR, 8'h00, ERR_UNTERM, '0);
                start_string();
            end
        end
        mark_last();
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == CH_QUOTE || ch == CH_BSLASH) begin
            ch = ch ^ 8'h01;
        end
        return ch;
    endfunction

    task automatic send_request(input logic [7:0] ch, input logic eol, input logic typed,
                                input t_res typed_res);
        int gap;
        gap = in_no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_in      <= ch;
        i_last_in_line <= eol;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decode_char(ch, eol);
        if (typed) begin
            step_results.delete();
            put_result(typed_res.kind, typed_res.data_byte, typed_res.error_code,
                       typed_res.string_length);
            mark_last();
        end
        foreach (step_results[k]) begin
            decoded_expect.push_back(step_results[k]);
        end
        requests_sent++;
    endtask

    task automatic send_body(input logic [7:0] ch);
        send_request(ch, $urandom_range(0, 39) == 0, 1'b0, NO_RES);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_expect.size() > 0);
    endtask

    task automatic send_string();
        int         parts;
        int         pick;
        int         d;
        logic [7:0] ch;
        parts = $urandom_range(0, 8);
        repeat (parts) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                send_body(pick_plain());
            end else if (pick < 6) begin
                send_body(CH_BSLASH);
                send_body(ESC_LETTERS[$urandom_range(0, 9)]);
            end else if (pick == 6) begin
                send_body(CH_BSLASH);
                send_body(CH_ZERO);
                repeat ($urandom_range(0, 4)) send_body(CH_ZERO + 8'($urandom_range(0, 7)));
            end else if (pick == 7) begin
                send_body(CH_BSLASH);
                send_body(CH_LC_X);
                repeat ($urandom_range(0, 3)) begin
                    d = $urandom_range(0, 21);
                    if (d < 10) begin
                        ch = CH_ZERO + 8'(d);
                    end else if (d < 16) begin
                        ch = CH_LC_A + 8'(d - 10);
                    end else begin
                        ch = CH_UC_A + 8'(d - 16);
                    end
                    send_body(ch);
                end
            end else if (pick == 8) begin
                send_body(8'($urandom_range(0, 255)));
            end else begin
                send_body(CH_BSLASH);
                send_body(8'($urandom_range(0, 255)));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            send_body(CH_QUOTE);
        end else if (pick < 8) begin
            send_request(pick_plain(), 1'b1, 1'b0, NO_RES);
        end else if (pick == 8) begin
            do begin
                ch = 8'($urandom_range(0, 255));
            end while (ch inside {CH_LC_A, CH_LC_B, CH_LC_T, CH_LC_N, CH_LC_V, CH_LC_F,
                                  CH_LC_R, CH_BSLASH, CH_APOS, CH_QUOTE, CH_ZERO, CH_LC_X});
            send_body(CH_BSLASH);
            send_body(ch);
        end
    endtask

    function automatic void report_result(string what, t_expect want, t_expect seen);
        fail_count++;
        if (fail_count <= 10) begin
            $display({"%s: expected kind %0d byte %h err %0d len %0d last %0d, ",
                      "got kind %0d byte %h err %0d len %0d last %0d"},
                     what, want.res.kind, want.res.data_byte, want.res.error_code,
                     want.res.string_length, want.last_of_run, seen.res.kind,
                     seen.res.data_byte, seen.res.error_code, seen.res.string_length,
                     seen.last_of_run);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_expect want;
        t_expect seen;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen = {o_kind, o_data_byte, o_error_code, o_string_length, o_last_of_run};
            if (decoded_expect.size() == 0) begin
                report_result("Unexpected result", '0, seen);
            end else begin
                want = decoded_expect.pop_front();
                if (seen !== want) begin
                    report_result("Result mismatch", want, seen);
                end
            end
        end
    end

    initial begin : idle_pattern
        forever begin
            repeat ($urandom_range(16, 160)) @(negedge i_clk);
            in_no_gaps    = ($urandom_range(0, 3) == 0);
            out_no_stalls = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : result_sink
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = out_no_stalls ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin : stimulus
        int base;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_char_in      = '0;
        i_last_in_line = 1'b0;
        start_string();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].ch, directed_rows[r].eol, directed_rows[r].typed,
                         directed_rows[r].res);
        end
        drain_results();

        base = requests_sent;
        while (requests_sent - base < RANDOM_REQS) begin
            send_string();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && decoded_expect.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
src/sedu_pkg.sv
src/sedu_decode.sv
src/sedu_rbuf.sv
src/string_literal_escape_decoder_unit.sv
bench/tb_string_literal_escape_decoder_unit.sv
